// ===== hdl/plfm_pkg.sv =====
// Shared constants, types and codes for the pinned LRU frame manager.
package plfm_pkg;
    localparam int FRAMES       = 16;
    localparam int PAGE_ID_BITS = 20;
    localparam int PIN_BITS     = 8;
    localparam int FRAME_BITS   = $clog2(FRAMES);

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_CREATE = 2'd1,
        OP_DIRTY  = 2'd2,
        OP_UNPIN  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE         = 3'd0,
        ST_PLACED       = 3'd1,
        ST_NO_FRAME     = 3'd2,
        ST_NOT_RESIDENT = 3'd3,
        ST_PIN_ZERO     = 3'd4
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,
        S_EMPTY  = 7'b0000100,
        S_LRU    = 7'b0001000,
        S_APPLY  = 7'b0010000,
        S_SHIFT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;
endpackage

// ===== hdl/plfm_recency.sv =====
// Recency list: one position compared or shifted per cycle.
module plfm_recency
    import plfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [FRAME_BITS-1:0] i_rd_pos,
    output logic [FRAME_BITS-1:0] o_rd_frame,
    input  logic                  i_shift,
    input  logic [FRAME_BITS-1:0] i_shift_pos,
    input  logic                  i_put_last,
    input  logic [FRAME_BITS-1:0] i_last_frame
);
    logic [FRAME_BITS-1:0] r_order [FRAMES];

    assign o_rd_frame = r_order[i_rd_pos];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) r_order[i] <= FRAME_BITS'(i);
        end else if (i_put_last) begin
            r_order[FRAMES-1] <= i_last_frame;
        end else if (i_shift) begin
            r_order[i_shift_pos] <= r_order[FRAME_BITS'(i_shift_pos + 1'b1)];
        end
    end
endmodule

// ===== hdl/pinned_lru_frame_manager.sv =====
// Top level of the pinned LRU frame manager: sequencer, frame table, result register.
//
//  channel | valid      | stall      | payload
//  input   | i_valid    | o_stall    | i_operation, i_page_id
//  output  | o_valid    | i_stall    | o_status .. o_writeback
//  config  | i_cfg_we   | -          | i_cfg_data
//
// One sequencer walks one frame per cycle for lookup, empty search and LRU search
// (up to FRAMES each), then moves the frame to the most recent slot.
// One transaction at a time; the next is taken the cycle after the result.
// Reset is synchronous: frames empty, pins and dirty clear, recency in frame order.
// o_stall is high from acceptance until the result has been taken.
module pinned_lru_frame_manager
    import plfm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [PAGE_ID_BITS-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_operation,
    input  logic [PAGE_ID_BITS-1:0] i_page_id,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_status,
    output logic [3:0]              o_frame,
    output logic [PAGE_ID_BITS-1:0] o_result_page_id,
    output logic                    o_load_needed,
    output logic                    o_evicted_valid,
    output logic [PAGE_ID_BITS-1:0] o_evicted_page_id,
    output logic                    o_writeback
);
    t_state r_state;
    t_op    r_op;
    logic [PAGE_ID_BITS-1:0] r_page, r_next_page;
    logic [FRAME_BITS-1:0]   r_idx;
    logic [FRAME_BITS-1:0]   r_frame;
    logic                    r_found;
    logic                    r_look_hit;

    logic                    r_vld [FRAMES];
    logic [PAGE_ID_BITS-1:0] r_fpage [FRAMES];
    logic [PIN_BITS-1:0]     r_pins [FRAMES];
    logic                    r_dirty [FRAMES];

    logic [FRAME_BITS-1:0] idx;
    logic [FRAME_BITS-1:0] rec_frame;
    logic                  last;
    logic                  shift, put_last;

    assign idx  = r_idx;
    assign last = (r_idx == FRAME_BITS'(FRAMES - 1));
    assign shift    = (r_state == S_SHIFT) && r_found && !last;
    assign put_last = (r_state == S_SHIFT) && (r_found && last);

    plfm_recency u_rec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_pos    (idx),
        .o_rd_frame  (rec_frame),
        .i_shift     (shift),
        .i_shift_pos (idx),
        .i_put_last  (put_last),
        .i_last_frame(r_frame)
    );

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_page <= '0;
            o_valid     <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_vld[i]   <= 1'b0;
                r_pins[i]  <= '0;
                r_dirty[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) r_next_page <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= t_op'(i_operation);
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        o_status          <= ST_DONE;
                        o_frame           <= '0;
                        o_load_needed     <= 1'b0;
                        o_evicted_valid   <= 1'b0;
                        o_evicted_page_id <= '0;
                        o_writeback       <= 1'b0;
                        if (t_op'(i_operation) == OP_CREATE) begin
                            o_result_page_id <= r_next_page;
                            r_page           <= r_next_page;
                            r_state          <= S_EMPTY;
                        end else begin
                            o_result_page_id <= i_page_id;
                            r_page           <= i_page_id;
                            r_state          <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    // one frame per cycle, lowest match wins
                    if (r_vld[idx] && r_fpage[idx] == r_page) begin
                        r_frame <= idx;
                        r_found <= 1'b1;
                        r_state <= S_APPLY;
                    end else if (last) begin
                        r_idx   <= '0;
                        r_state <= (r_op == OP_GET) ? S_EMPTY : S_APPLY;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMPTY: begin
                    if (!r_vld[idx]) begin
                        r_frame <= idx;
                        r_found <= 1'b1;
                        r_state <= S_APPLY;
                    end else if (last) begin
                        r_idx   <= '0;
                        r_state <= S_LRU;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LRU: begin
                    if (r_pins[rec_frame] == '0) begin
                        r_frame <= rec_frame;
                        r_found <= 1'b1;
                        r_state <= S_APPLY;
                    end else if (last) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_APPLY: begin
                    r_idx <= '0;
                    if (!r_found) begin
                        r_state  <= S_OUT;
                        o_status <= (r_op == OP_GET || r_op == OP_CREATE)
                                    ? ST_NO_FRAME : ST_NOT_RESIDENT;
                    end else begin
                        o_frame <= 4'(r_frame);
                        case (r_op)
                            OP_DIRTY: begin
                                r_state          <= S_OUT;
                                r_dirty[r_frame] <= 1'b1;
                            end
                            OP_UNPIN: begin
                                r_state <= S_OUT;
                                if (r_pins[r_frame] == '0) o_status <= ST_PIN_ZERO;
                                else r_pins[r_frame] <= r_pins[r_frame] - 1'b1;
                            end
                            default: begin
                                r_state <= S_SHIFT;
                                r_found <= 1'b0;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // find frame in order, then close the gap and append
                    if (put_last) begin
                        r_state <= S_OUT;
                    end else if (!r_found) begin
                        if (rec_frame == r_frame) begin
                            r_found <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    if (o_valid && !i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        o_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // frame update at the start of the recency pass
            if (r_state == S_APPLY && r_found
                && (r_op == OP_GET || r_op == OP_CREATE)) begin
                if (r_op == OP_GET && r_vld[r_frame] && r_fpage[r_frame] == r_page
                    && r_look_hit) begin
                    if (r_pins[r_frame] != PIN_MAX)
                        r_pins[r_frame] <= r_pins[r_frame] + 1'b1;
                end else begin
                    o_status        <= ST_PLACED;
                    o_evicted_valid <= r_vld[r_frame];
                    if (r_vld[r_frame]) begin
                        o_evicted_page_id <= r_fpage[r_frame];
                        o_writeback       <= r_dirty[r_frame];
                    end
                    o_load_needed    <= (r_op == OP_GET);
                    r_vld[r_frame]   <= 1'b1;
                    r_fpage[r_frame] <= r_page;
                    r_pins[r_frame]  <= PIN_BITS'(1);
                    r_dirty[r_frame] <= (r_op == OP_CREATE);
                    if (r_op == OP_CREATE && !i_cfg_we) r_next_page <= r_next_page + 1'b1;
                end
            end
        end
    end

    // hit flag: set when the lookup walk matched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look_hit <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_look_hit <= 1'b0;
        end else if (r_state == S_LOOK && r_vld[idx] && r_fpage[idx] == r_page) begin
            r_look_hit <= 1'b1;
        end
    end
endmodule

// ===== hdl/plfm_checker.sv =====
// Port-level checker for the pinned LRU frame manager, bound to the top level.
module plfm_checker
    import plfm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input logic       o_load_needed,
    input logic       o_evicted_valid,
    input logic       o_writeback
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_PIN_ZERO)) else $error("bad status");
    a_load_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_load_needed |-> o_status == ST_PLACED) else $error("load w/o place");
    a_wb_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_writeback |-> o_evicted_valid) else $error("writeback w/o evict");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result while ready");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)) else $error("result dropped");
endmodule

bind pinned_lru_frame_manager plfm_checker u_plfm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_load_needed(o_load_needed), .o_evicted_valid(o_evicted_valid),
    .o_writeback(o_writeback)
);
